// ===== sv/tdsb_pkg.sv =====
// Shared types and constants for the time/distance slope-bound compressor.
// No dependencies; every other file in sv/ refers to this package by scope.
`timescale 1ns / 1ps

package tdsb_pkg;

    // Field widths fixed by the point and result formats
    localparam int TIME_W   = 31;
    localparam int DIST_W   = 31;
    localparam int INDEX_W  = 16;
    localparam int TOL_W    = 20;
    localparam int SPEED_W  = 48;
    // Divider operands: signed numerator, unsigned positive denominator
    localparam int NUM_W    = 33;
    localparam int DEN_W    = 32;
    localparam int CFG_IDX_W = 1;

    typedef logic [TIME_W-1:0]         t_time;
    typedef logic [DIST_W-1:0]         t_dist;
    typedef logic [INDEX_W-1:0]        t_index;
    typedef logic [TOL_W-1:0]          t_tol;
    typedef logic signed [SPEED_W-1:0] t_speed;
    typedef logic signed [NUM_W-1:0]   t_num;
    typedef logic [DEN_W-1:0]          t_den;

    localparam t_time  TIME_MAX      = 31'h7FFF_FFFF;
    localparam t_tol   TOL_RESET     = 20'd9000;
    localparam t_speed SPEED_MAX     = 48'sh7FFF_FFFF_FFFF;
    localparam t_speed SPEED_MIN     = 48'sh8000_0000_0000;
    localparam logic [SPEED_W-1:0] SPEED_MAX_MAG = 48'h7FFF_FFFF_FFFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIST_TOL = 1'b0,
        CFG_TIME_TOL = 1'b1
    } t_cfg_idx;

    // One kept point
    typedef struct packed {
        t_index kept_index;
        t_time  kept_time;
        t_dist  kept_distance;
        logic   run_end;
    } t_result;

    // Divider request / response
    typedef struct packed {
        logic start;
        t_num num;
        t_den den;
    } t_div_req;

    typedef struct packed {
        logic   busy;
        logic   done;
        t_speed quo;
    } t_div_rsp;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_LOAD,
        DV_RUN,
        DV_FIX
    } t_div_state;

    // Window narrowing steps, in issue order
    typedef enum logic [1:0] {
        NOP_LO_DIST,
        NOP_UP_DIST,
        NOP_LO_TIME,
        NOP_UP_TIME
    } t_nar_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_PREP,
        S_CHECK,
        S_SPEED,
        S_CHKW,
        S_BREAK,
        S_NSTART,
        S_NWAIT,
        S_FINISH
    } t_seq_state;

endpackage

// ===== sv/tdsb_in_if.sv =====
// Point input channel: valid/ready handshake with the point payload.
// Depends on tdsb_pkg for field types.
`timescale 1ns / 1ps

interface tdsb_in_if;
    logic           valid;
    logic           ready;
    tdsb_pkg::t_time point_time;
    tdsb_pkg::t_dist point_distance;
    logic           final_point;

    modport source (output valid, point_time, point_distance, final_point, input ready);
    modport sink   (input valid, point_time, point_distance, final_point, output ready);
endinterface

// ===== sv/tdsb_out_if.sv =====
// Kept-point output channel: valid/ready handshake with the result payload.
// Depends on tdsb_pkg for field types.
`timescale 1ns / 1ps

interface tdsb_out_if;
    logic             valid;
    logic             ready;
    tdsb_pkg::t_index kept_index;
    tdsb_pkg::t_time  kept_time;
    tdsb_pkg::t_dist  kept_distance;
    logic             run_end;

    modport source (output valid, kept_index, kept_time, kept_distance, run_end, input ready);
    modport sink   (input valid, kept_index, kept_time, kept_distance, run_end, output ready);
endinterface

// ===== sv/time_distance_slope_bound_compressor_unit.sv =====
// Time/distance slope-bound trajectory compressor. One point is taken per input
// beat; the block then works on it alone and raises ready again when done. Each
// point after the first takes one pass of the shared divider per speed it
// computes: the check of the anchor speed and up to four window-narrowing
// quotients, so up to five passes. A pass loads the operands, produces one
// quotient bit per cycle over a 33 + SPEED_FRACTION_BITS bit dividend, then
// applies the fix-up and hands the result back. A point that breaks the
// window or ends the trajectory also waits for the output register to be free.
// Each kept point leaves as one output beat; at most two beats per point.
// Depends on tdsb_pkg, tdsb_in_if, tdsb_out_if, tdsb_div and tdsb_outreg.
`timescale 1ns / 1ps

module time_distance_slope_bound_compressor_unit #(
    parameter int SPEED_FRACTION_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tdsb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tdsb_pkg::TOL_W-1:0]       i_cfg_data,
    tdsb_in_if.sink                          i_pt,
    tdsb_out_if.source                       o_kept
);

    tdsb_pkg::t_seq_state r_state, n_state;
    tdsb_pkg::t_tol       r_dist_tol, r_time_tol;
    tdsb_pkg::t_time      r_cur_t, n_cur_t;
    tdsb_pkg::t_dist      r_cur_d, n_cur_d;
    logic                 r_fin, n_fin;
    tdsb_pkg::t_time      r_anc_t, n_anc_t;
    tdsb_pkg::t_dist      r_anc_d, n_anc_d;
    tdsb_pkg::t_time      r_prev_t, n_prev_t;
    tdsb_pkg::t_dist      r_prev_d, n_prev_d;
    tdsb_pkg::t_speed     r_upper, n_upper;
    tdsb_pkg::t_speed     r_lower, n_lower;
    tdsb_pkg::t_index     r_cnt, n_cnt;
    tdsb_pkg::t_index     r_idx, n_idx;
    logic                 r_started, n_started;
    tdsb_pkg::t_time      r_td, n_td;
    tdsb_pkg::t_dist      r_dd, n_dd;
    tdsb_pkg::t_nar_op    r_op, n_op;

    tdsb_pkg::t_div_req   w_div_req;
    tdsb_pkg::t_div_rsp   w_div_rsp;
    tdsb_pkg::t_result    w_beat;
    logic                 w_load;
    logic                 w_free;
    logic                 w_accept;

    tdsb_pkg::t_num       w_dd_n;
    tdsb_pkg::t_num       w_dtol_n;
    tdsb_pkg::t_den       w_td_n;
    tdsb_pkg::t_den       w_ttol_n;

    assign i_pt.ready = (r_state == tdsb_pkg::S_IDLE);
    assign w_accept   = i_pt.valid && i_pt.ready;

    // Operand extensions for the divider
    assign w_dd_n   = {2'b00, r_dd};
    assign w_dtol_n = {{(tdsb_pkg::NUM_W - tdsb_pkg::TOL_W){1'b0}}, r_dist_tol};
    assign w_td_n   = {1'b0, r_td};
    assign w_ttol_n = {{(tdsb_pkg::DEN_W - tdsb_pkg::TOL_W){1'b0}}, r_time_tol};

    // Shared divider
    tdsb_div #(
        .FRAC_BITS (SPEED_FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Output register
    tdsb_outreg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_beat  (w_beat),
        .o_free  (w_free),
        .o_kept  (o_kept)
    );

    // Sequencer: next state, datapath updates and unit requests
    always_comb begin
        n_state   = r_state;
        n_cur_t   = r_cur_t;
        n_cur_d   = r_cur_d;
        n_fin     = r_fin;
        n_anc_t   = r_anc_t;
        n_anc_d   = r_anc_d;
        n_prev_t  = r_prev_t;
        n_prev_d  = r_prev_d;
        n_upper   = r_upper;
        n_lower   = r_lower;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_started = r_started;
        n_td      = r_td;
        n_dd      = r_dd;
        n_op      = r_op;
        w_div_req = '{start: 1'b0, num: w_dd_n, den: w_td_n};
        w_load    = 1'b0;
        w_beat    = '{kept_index: r_idx, kept_time: r_cur_t,
                      kept_distance: r_cur_d, run_end: r_fin};

        unique case (r_state)
            tdsb_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_cur_t = i_pt.point_time;
                    n_cur_d = i_pt.point_distance;
                    n_fin   = i_pt.final_point;
                    n_state = r_started ? tdsb_pkg::S_PREP : tdsb_pkg::S_FIRST;
                end
            end
            // First point of a trajectory: emit and anchor
            tdsb_pkg::S_FIRST: begin
                if (w_free) begin
                    w_load          = 1'b1;
                    w_beat.kept_index = '0;
                    n_anc_t   = r_cur_t;
                    n_anc_d   = r_cur_d;
                    n_prev_t  = r_cur_t;
                    n_prev_d  = r_cur_d;
                    n_upper   = tdsb_pkg::SPEED_MAX;
                    n_lower   = tdsb_pkg::SPEED_MIN;
                    n_cnt     = r_fin ? '0 : tdsb_pkg::t_index'(1);
                    n_started = !r_fin;
                    n_state   = tdsb_pkg::S_IDLE;
                end
            end
            // Force distance non-decreasing and time strictly increasing
            tdsb_pkg::S_PREP: begin
                if (r_cur_d < r_prev_d) begin
                    n_cur_d = r_prev_d;
                end
                if (r_cur_t <= r_prev_t) begin
                    n_cur_t = (r_prev_t != tdsb_pkg::TIME_MAX)
                            ? r_prev_t + tdsb_pkg::t_time'(1) : tdsb_pkg::TIME_MAX;
                end
                n_idx   = r_cnt;
                n_state = tdsb_pkg::S_CHECK;
            end
            tdsb_pkg::S_CHECK: begin
                n_td    = r_cur_t - r_anc_t;
                n_dd    = r_cur_d - r_anc_d;
                n_state = tdsb_pkg::S_SPEED;
            end
            // Speed from the anchor
            tdsb_pkg::S_SPEED: begin
                if (r_td == '0) begin
                    n_state = tdsb_pkg::S_FINISH;
                end else begin
                    w_div_req.start = 1'b1;
                    n_state         = tdsb_pkg::S_CHKW;
                end
            end
            tdsb_pkg::S_CHKW: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.quo < r_lower || w_div_rsp.quo > r_upper) begin
                        n_state = tdsb_pkg::S_BREAK;
                    end else begin
                        n_op    = tdsb_pkg::NOP_LO_DIST;
                        n_state = tdsb_pkg::S_NSTART;
                    end
                end
            end
            // Window broken: emit the previous point and re-anchor on it
            tdsb_pkg::S_BREAK: begin
                if (w_free) begin
                    w_load = 1'b1;
                    w_beat = '{kept_index: r_idx - tdsb_pkg::t_index'(1),
                               kept_time: r_prev_t, kept_distance: r_prev_d,
                               run_end: 1'b0};
                    n_anc_t = r_prev_t;
                    n_anc_d = r_prev_d;
                    n_upper = tdsb_pkg::SPEED_MAX;
                    n_lower = tdsb_pkg::SPEED_MIN;
                    n_td    = r_cur_t - r_prev_t;
                    n_dd    = r_cur_d - r_prev_d;
                    n_op    = tdsb_pkg::NOP_LO_DIST;
                    n_state = tdsb_pkg::S_NSTART;
                end
            end
            // Issue one narrowing quotient
            tdsb_pkg::S_NSTART: begin
                if (r_td == '0) begin
                    n_state = tdsb_pkg::S_FINISH;
                end else begin
                    w_div_req.start = 1'b1;
                    n_state         = tdsb_pkg::S_NWAIT;
                    unique case (r_op)
                        tdsb_pkg::NOP_LO_DIST: w_div_req.num = w_dd_n - w_dtol_n;
                        tdsb_pkg::NOP_UP_DIST: w_div_req.num = w_dd_n + w_dtol_n;
                        tdsb_pkg::NOP_LO_TIME: w_div_req.den = w_td_n + w_ttol_n;
                        tdsb_pkg::NOP_UP_TIME: begin
                            if (w_td_n > w_ttol_n) begin
                                w_div_req.den = w_td_n - w_ttol_n;
                            end else begin
                                w_div_req.start = 1'b0;
                                n_state         = tdsb_pkg::S_FINISH;
                            end
                        end
                        default: n_state = tdsb_pkg::S_FINISH;
                    endcase
                end
            end
            // Fold the quotient into the window
            tdsb_pkg::S_NWAIT: begin
                if (w_div_rsp.done) begin
                    n_state = tdsb_pkg::S_NSTART;
                    unique case (r_op)
                        tdsb_pkg::NOP_LO_DIST: begin
                            if (w_div_rsp.quo > r_lower) n_lower = w_div_rsp.quo;
                            n_op = tdsb_pkg::NOP_UP_DIST;
                        end
                        tdsb_pkg::NOP_UP_DIST: begin
                            if (w_div_rsp.quo < r_upper) n_upper = w_div_rsp.quo;
                            n_op = tdsb_pkg::NOP_LO_TIME;
                        end
                        tdsb_pkg::NOP_LO_TIME: begin
                            if (w_div_rsp.quo > r_lower) n_lower = w_div_rsp.quo;
                            n_op = tdsb_pkg::NOP_UP_TIME;
                        end
                        tdsb_pkg::NOP_UP_TIME: begin
                            if (w_div_rsp.quo < r_upper) n_upper = w_div_rsp.quo;
                            n_state = tdsb_pkg::S_FINISH;
                        end
                        default: n_state = tdsb_pkg::S_FINISH;
                    endcase
                end
            end
            // Commit the point; the final one is always kept
            tdsb_pkg::S_FINISH: begin
                n_prev_t = r_cur_t;
                n_prev_d = r_cur_d;
                if (r_fin) begin
                    if (w_free) begin
                        w_load    = 1'b1;
                        n_cnt     = '0;
                        n_started = 1'b0;
                        n_state   = tdsb_pkg::S_IDLE;
                    end
                end else begin
                    n_cnt   = r_cnt + tdsb_pkg::t_index'(1);
                    n_state = tdsb_pkg::S_IDLE;
                end
            end
            default: n_state = tdsb_pkg::S_IDLE;
        endcase
    end

    // State register and trajectory state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tdsb_pkg::S_IDLE;
            r_started <= 1'b0;
            r_cnt     <= '0;
            r_anc_t   <= '0;
            r_anc_d   <= '0;
            r_prev_t  <= '0;
            r_prev_d  <= '0;
            r_upper   <= tdsb_pkg::SPEED_MAX;
            r_lower   <= tdsb_pkg::SPEED_MIN;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_cnt     <= n_cnt;
            r_anc_t   <= n_anc_t;
            r_anc_d   <= n_anc_d;
            r_prev_t  <= n_prev_t;
            r_prev_d  <= n_prev_d;
            r_upper   <= n_upper;
            r_lower   <= n_lower;
        end
    end

    // Working registers of the current point
    always_ff @(posedge i_clk) begin
        r_cur_t <= n_cur_t;
        r_cur_d <= n_cur_d;
        r_fin   <= n_fin;
        r_idx   <= n_idx;
        r_td    <= n_td;
        r_dd    <= n_dd;
        r_op    <= n_op;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_tol <= tdsb_pkg::TOL_RESET;
            r_time_tol <= tdsb_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (tdsb_pkg::t_cfg_idx'(i_cfg_idx))
                tdsb_pkg::CFG_DIST_TOL: r_dist_tol <= i_cfg_data;
                tdsb_pkg::CFG_TIME_TOL: r_time_tol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Checks
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == tdsb_pkg::S_PREP || r_state == tdsb_pkg::S_FIRST))
        else $error("accepted beat not taken into work");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_free)
        else $error("output register overwritten");

    a_nwait_td: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdsb_pkg::S_NWAIT) |-> (r_td != '0))
        else $error("narrowing with zero time difference");

endmodule

// ===== sv/tdsb_div.sv =====
// Shared restoring divider: floor(num * 2^FRAC_BITS / den), saturated to speed.
// One quotient bit per cycle. Depends on tdsb_pkg.
`timescale 1ns / 1ps

module tdsb_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tdsb_pkg::t_div_req  i_req,
    output tdsb_pkg::t_div_rsp  o_rsp
);

    localparam int DW = tdsb_pkg::NUM_W + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);
    localparam int QW = (DW > tdsb_pkg::SPEED_W) ? DW + 1 : tdsb_pkg::SPEED_W + 1;
    localparam logic [QW-1:0] POS_LIM =
        {{(QW - tdsb_pkg::SPEED_W){1'b0}}, tdsb_pkg::SPEED_MAX_MAG};
    localparam logic [QW-1:0] NEG_LIM = POS_LIM + {{(QW - 1){1'b0}}, 1'b1};

    tdsb_pkg::t_div_state r_st, n_st;
    tdsb_pkg::t_num       r_num, n_num;
    tdsb_pkg::t_den       r_den, n_den;
    logic [DW-1:0]        r_dvd, n_dvd;
    tdsb_pkg::t_den       r_rem, n_rem;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_neg, n_neg;
    tdsb_pkg::t_speed     r_quo, n_quo;
    logic                 r_done, n_done;

    logic [tdsb_pkg::NUM_W-1:0]   w_mag;
    logic [tdsb_pkg::DEN_W:0]     w_rem_sh;
    logic [tdsb_pkg::DEN_W:0]     w_rem_sub;
    logic                         w_ge;
    logic [QW-1:0]                w_m;
    logic [tdsb_pkg::SPEED_W-1:0] w_m_lo;

    // Operand magnitude and one restoring step
    assign w_mag     = r_num[tdsb_pkg::NUM_W-1] ? tdsb_pkg::NUM_W'(-r_num)
                                                : tdsb_pkg::NUM_W'(r_num);
    assign w_rem_sh  = {r_rem, r_dvd[DW-1]};
    assign w_ge      = w_rem_sh >= {1'b0, r_den};
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};

    // Floor correction for negative numerators: -(q + (rem != 0))
    assign w_m    = {{(QW - DW){1'b0}}, r_dvd}
                  + {{(QW - 1){1'b0}}, (r_neg && (r_rem != '0))};
    assign w_m_lo = w_m[tdsb_pkg::SPEED_W-1:0];

    // Sequencer
    always_comb begin
        n_st   = r_st;
        n_num  = r_num;
        n_den  = r_den;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_quo  = r_quo;
        n_done = 1'b0;
        unique case (r_st)
            tdsb_pkg::DV_IDLE: begin
                if (i_req.start) begin
                    n_num = i_req.num;
                    n_den = i_req.den;
                    n_st  = tdsb_pkg::DV_LOAD;
                end
            end
            tdsb_pkg::DV_LOAD: begin
                n_neg = r_num[tdsb_pkg::NUM_W-1];
                n_dvd = {w_mag, {FRAC_BITS{1'b0}}};
                n_rem = '0;
                n_cnt = CW'(DW);
                n_st  = tdsb_pkg::DV_RUN;
            end
            tdsb_pkg::DV_RUN: begin
                n_rem = w_ge ? w_rem_sub[tdsb_pkg::DEN_W-1:0]
                             : w_rem_sh[tdsb_pkg::DEN_W-1:0];
                n_dvd = {r_dvd[DW-2:0], w_ge};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_st = tdsb_pkg::DV_FIX;
                end
            end
            tdsb_pkg::DV_FIX: begin
                if (!r_neg) begin
                    n_quo = (w_m > POS_LIM) ? tdsb_pkg::SPEED_MAX
                                            : tdsb_pkg::t_speed'(w_m_lo);
                end else begin
                    n_quo = (w_m > NEG_LIM) ? tdsb_pkg::SPEED_MIN
                                            : tdsb_pkg::t_speed'(~w_m_lo + 48'd1);
                end
                n_done = 1'b1;
                n_st   = tdsb_pkg::DV_IDLE;
            end
            default: n_st = tdsb_pkg::DV_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= tdsb_pkg::DV_IDLE;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_den <= n_den;
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_neg <= n_neg;
        r_quo <= n_quo;
    end

    assign o_rsp.busy = (r_st != tdsb_pkg::DV_IDLE);
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    // Checks
    a_run_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == tdsb_pkg::DV_RUN) |-> (r_cnt != '0))
        else $error("divider running with zero step count");

    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_st == tdsb_pkg::DV_FIX))
        else $error("divider done without a fix-up step");

    a_start_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == tdsb_pkg::DV_IDLE && i_req.start) |=> (r_st == tdsb_pkg::DV_LOAD))
        else $error("divider ignored a start");

endmodule

// ===== sv/tdsb_outreg.sv =====
// Output holding register: one kept-point beat, freed as the sink takes it.
// Depends on tdsb_pkg and tdsb_out_if.
`timescale 1ns / 1ps

module tdsb_outreg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tdsb_pkg::t_result i_beat,
    output logic              o_free,
    tdsb_out_if.source        o_kept
);

    logic              r_valid;
    tdsb_pkg::t_result r_beat;

    // Slot can take a new beat when empty or being drained this cycle
    assign o_free = !r_valid || o_kept.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_kept.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= i_beat;
        end
    end

    assign o_kept.valid         = r_valid;
    assign o_kept.kept_index    = r_beat.kept_index;
    assign o_kept.kept_time     = r_beat.kept_time;
    assign o_kept.kept_distance = r_beat.kept_distance;
    assign o_kept.run_end       = r_beat.run_end;

endmodule

// ===== bench/time_distance_slope_bound_compressor_unit_test.sv =====
// Self-checking bench for the time/distance slope-bound compressor: directed point table,
// then random trajectories under several tolerance settings and handshake idling modes.
// Depends on tdsb_pkg, tdsb_in_if, tdsb_out_if and the compressor RTL.
`timescale 1ns / 1ps

module time_distance_slope_bound_compressor_unit_test;

    localparam int SPEED_FRACTION_BITS = 16;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int NUM_PHASES = 6;
    // One point costs up to five divider passes
    localparam int SETTLE_CYCLES = 400;
    localparam int DRAIN_LIMIT = 40000;
    localparam int HOLD_CYCLES = 4000;
    localparam longint COORD_TOP = 64'h7FFF_FFFF;
    localparam tdsb_pkg::t_dist DIST_TOP = '1;
    localparam tdsb_pkg::t_tol TOL_TOP = '1;
    localparam tdsb_pkg::t_time T_MAX = tdsb_pkg::TIME_MAX;

    typedef struct {
        tdsb_pkg::t_time   t;
        tdsb_pkg::t_dist   d;
        logic              fin;
        bit                typed;
        tdsb_pkg::t_result want;
    } t_point_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [tdsb_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [tdsb_pkg::TOL_W-1:0] i_cfg_data = '0;

    tdsb_in_if  pt_bus();
    tdsb_out_if kept_bus();

    time_distance_slope_bound_compressor_unit #(
        .SPEED_FRACTION_BITS(SPEED_FRACTION_BITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_pt      (pt_bus),
        .o_kept    (kept_bus)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: tolerances, anchor, last point, speed window, position
    tdsb_pkg::t_tol   dist_tol = tdsb_pkg::TOL_RESET;
    tdsb_pkg::t_tol   time_tol = tdsb_pkg::TOL_RESET;
    tdsb_pkg::t_time  anchor_t, prev_t;
    tdsb_pkg::t_dist  anchor_d, prev_d;
    longint           upper_spd, lower_spd;
    tdsb_pkg::t_index pos_count;
    bit               traj_open;

    tdsb_pkg::t_result kept_queue[$];
    int mismatches = 0;
    int points_sent = 0;
    int trajectories = 0;
    int kept_checked = 0;
    int double_kept = 0;
    int settings_used = 1;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;

    t_point_row directed_rows [19];

    task automatic flag_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Floor of num * 2^F / den, saturated to the 48-bit speed range
    function automatic longint speed_quot(longint num, longint den);
        longint scaled;
        longint q;
        scaled = num * (longint'(1) << SPEED_FRACTION_BITS);
        q = scaled / den;
        if (scaled % den != 0 && scaled < 0) q = q - 1;
        if (q > longint'(tdsb_pkg::SPEED_MAX)) q = longint'(tdsb_pkg::SPEED_MAX);
        if (q < longint'(tdsb_pkg::SPEED_MIN)) q = longint'(tdsb_pkg::SPEED_MIN);
        return q;
    endfunction

    function automatic void open_window();
        upper_spd = longint'(tdsb_pkg::SPEED_MAX);
        lower_spd = longint'(tdsb_pkg::SPEED_MIN);
    endfunction

    function automatic void narrow_window(longint td, longint dd);
        longint s;
        longint dtol;
        longint ttol;
        dtol = longint'(dist_tol);
        ttol = longint'(time_tol);
        s = speed_quot(dd - dtol, td);
        if (s > lower_spd) lower_spd = s;
        s = speed_quot(dd + dtol, td);
        if (s < upper_spd) upper_spd = s;
        s = speed_quot(dd, td + ttol);
        if (s > lower_spd) lower_spd = s;
        if (td > ttol) begin
            s = speed_quot(dd, td - ttol);
            if (s < upper_spd) upper_spd = s;
        end
    endfunction

    // Kept points caused by one accepted point
    function automatic void predict_point(input tdsb_pkg::t_time t_in,
                                          input tdsb_pkg::t_dist d_in,
                                          input logic fin,
                                          output tdsb_pkg::t_result res [2],
                                          output int n);
        tdsb_pkg::t_time  t;
        tdsb_pkg::t_dist  d;
        tdsb_pkg::t_index idx;
        longint td, dd, s;
        n = 0;
        t = t_in;
        d = d_in;
        if (!traj_open) begin
            anchor_t = t;
            prev_t = t;
            anchor_d = d;
            prev_d = d;
            open_window();
            res[0] = '{kept_index: '0, kept_time: t, kept_distance: d, run_end: fin};
            n = 1;
            pos_count = fin ? tdsb_pkg::t_index'(0) : tdsb_pkg::t_index'(1);
            traj_open = !fin;
            return;
        end
        idx = pos_count;
        // distance never goes back, time always moves on (saturating)
        if (d < prev_d) d = prev_d;
        if (t <= prev_t) t = (prev_t < T_MAX) ? prev_t + tdsb_pkg::t_time'(1) : T_MAX;
        td = longint'(t) - longint'(anchor_t);
        dd = longint'(d) - longint'(anchor_d);
        if (td > 0) begin
            s = speed_quot(dd, td);
            if (s < lower_spd || s > upper_spd) begin
                res[n] = '{kept_index: idx - tdsb_pkg::t_index'(1), kept_time: prev_t,
                           kept_distance: prev_d, run_end: 1'b0};
                n++;
                anchor_t = prev_t;
                anchor_d = prev_d;
                open_window();
                td = longint'(t) - longint'(anchor_t);
                dd = longint'(d) - longint'(anchor_d);
            end
            if (td > 0) narrow_window(td, dd);
        end
        prev_t = t;
        prev_d = d;
        if (fin) begin
            res[n] = '{kept_index: idx, kept_time: t, kept_distance: d, run_end: 1'b1};
            n++;
            pos_count = '0;
            traj_open = 1'b0;
        end else begin
            pos_count = pos_count + tdsb_pkg::t_index'(1);
        end
    endfunction

    // One point beat; typed rows queue the table's result instead of the prediction
    task automatic send_point(tdsb_pkg::t_time t, tdsb_pkg::t_dist d, logic fin,
                              bit typed = 1'b0, tdsb_pkg::t_result want = '0);
        tdsb_pkg::t_result res [2];
        int n;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            pt_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        pt_bus.valid <= 1'b1;
        pt_bus.point_time <= t;
        pt_bus.point_distance <= d;
        pt_bus.final_point <= fin;
        do @(posedge i_clk); while (!pt_bus.ready);
        predict_point(t, d, fin, res, n);
        if (typed) begin
            kept_queue.push_back(want);
        end else begin
            for (int i = 0; i < n; i++) kept_queue.push_back(res[i]);
        end
        points_sent++;
        if (fin) trajectories++;
        if (n == 2) double_kept++;
    endtask

    task automatic drain_kept();
        int waited;
        waited = 0;
        @(negedge i_clk);
        pt_bus.valid <= 1'b0;
        while (kept_queue.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tol(tdsb_pkg::t_cfg_idx idx, tdsb_pkg::t_tol val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        unique case (idx)
            tdsb_pkg::CFG_DIST_TOL: dist_tol = val;
            tdsb_pkg::CFG_TIME_TOL: time_tol = val;
            default: ;
        endcase
    endtask

    function automatic longint clamp_coord(longint v);
        if (v < 0) return 0;
        if (v > COORD_TOP) return COORD_TOP;
        return v;
    endfunction

    function automatic longint pick_base();
        case ($urandom_range(9))
            7, 8: return longint'($urandom) & COORD_TOP;
            9: return COORD_TOP - $urandom_range(0, 20000);
            default: return $urandom_range(0, 100000);
        endcase
    endfunction

    // Mostly smooth motion at a drifting rate, with jumps, stops, reversals and noise
    task automatic run_trajectory();
        int len;
        int kind;
        longint t, d, dt, dd, rate;
        case ($urandom_range(19))
            0, 1: len = 1;
            2, 3, 4: len = $urandom_range(11, 40);
            5: len = $urandom_range(41, 120);
            default: len = $urandom_range(2, 10);
        endcase
        t = pick_base();
        d = pick_base();
        rate = $urandom_range(0, 1 << 14);
        for (int k = 0; k < len; k++) begin
            if (k > 0) begin
                kind = $urandom_range(99);
                if (kind < 6) begin
                    t = longint'($urandom) & COORD_TOP;
                    d = longint'($urandom) & COORD_TOP;
                end else if (kind < 12) begin
                    t = clamp_coord(t - $urandom_range(0, 50));
                    d = clamp_coord(d - $urandom_range(0, 500));
                end else begin
                    dt = ($urandom_range(9) < 8) ? $urandom_range(1, 4000)
                                                 : $urandom_range(1, 1 << 24);
                    if ($urandom_range(4) == 0) rate = $urandom_range(0, 1 << 14);
                    dd = (dt * rate) / 256 + longint'($urandom_range(0, 3000)) - 1500;
                    t = clamp_coord(t + dt);
                    d = clamp_coord(d + dd);
                end
            end
            send_point(tdsb_pkg::t_time'(t), tdsb_pkg::t_dist'(d), k == len - 1);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off when asked
    always @(negedge i_clk) begin
        if (holds_served != holds_asked) begin
            holds_served <= holds_asked;
            hold_left <= HOLD_CYCLES;
            kept_bus.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            kept_bus.ready <= 1'b0;
        end else begin
            kept_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each kept-point beat with the oldest expectation
    always @(posedge i_clk) begin
        tdsb_pkg::t_result want;
        if (i_rst_n && kept_bus.valid && kept_bus.ready) begin
            if (kept_queue.size() == 0) begin
                flag_mismatch($sformatf("kept point %0d (t=%0d) with nothing expected",
                                        kept_bus.kept_index, kept_bus.kept_time));
            end else begin
                want = kept_queue.pop_front();
                kept_checked++;
                if (kept_bus.kept_index !== want.kept_index)
                    flag_mismatch($sformatf("kept_index %0d, expected %0d",
                                            kept_bus.kept_index, want.kept_index));
                if (kept_bus.kept_time !== want.kept_time)
                    flag_mismatch($sformatf("kept_time %0d, expected %0d",
                                            kept_bus.kept_time, want.kept_time));
                if (kept_bus.kept_distance !== want.kept_distance)
                    flag_mismatch($sformatf("kept_distance %0d, expected %0d",
                                            kept_bus.kept_distance, want.kept_distance));
                if (kept_bus.run_end !== want.run_end)
                    flag_mismatch($sformatf("run_end %0b, expected %0b",
                                            kept_bus.run_end, want.run_end));
            end
        end
    end

    // Run guard
    initial begin
        #20_000_000;
        $display("time_distance_slope_bound_compressor_unit verification failed");
        $finish;
    end

    initial begin
        tdsb_pkg::t_tol dtol_set, ttol_set;
        int phase_start;
        bit paused;
        pt_bus.valid = 1'b0;
        pt_bus.point_time = '0;
        pt_bus.point_distance = '0;
        pt_bus.final_point = 1'b0;
        anchor_t = '0;
        anchor_d = '0;
        prev_t = '0;
        prev_d = '0;
        open_window();
        pos_count = '0;
        traj_open = 1'b0;

        // Directed points at reset tolerances; typed rows give the kept point directly
        directed_rows = '{
            '{31'd100, 31'd0, 1'b0, 1'b1, '{16'd0, 31'd100, 31'd0, 1'b0}},
            '{31'd1100, 31'd1000, 1'b0, 1'b0, '0},
            '{31'd2100, 31'd2000, 1'b0, 1'b0, '0},
            '{31'd2101, 31'd900000, 1'b0, 1'b0, '0},   // speed jump breaks
            '{31'd2000, 31'd10, 1'b0, 1'b0, '0},       // time and distance go back
            '{31'd5000, 31'd905000, 1'b0, 1'b0, '0},
            '{31'd5001, 31'd40000000, 1'b1, 1'b0, '0}, // break on the final point
            '{31'd0, 31'd0, 1'b1, 1'b1, '{16'd0, 31'd0, 31'd0, 1'b1}},
            '{T_MAX, DIST_TOP, 1'b0, 1'b1, '{16'd0, T_MAX, DIST_TOP, 1'b0}},
            '{T_MAX, DIST_TOP, 1'b0, 1'b0, '0},        // time pinned at the top
            '{31'd0, 31'd0, 1'b1, 1'b1, '{16'd2, T_MAX, DIST_TOP, 1'b1}},
            '{31'd0, 31'd0, 1'b0, 1'b1, '{16'd0, 31'd0, 31'd0, 1'b0}},
            '{31'd1, DIST_TOP, 1'b0, 1'b0, '0},        // speed saturates high
            '{31'd2, DIST_TOP, 1'b0, 1'b0, '0},
            '{T_MAX, DIST_TOP, 1'b0, 1'b0, '0},
            '{T_MAX, DIST_TOP, 1'b1, 1'b0, '0},
            '{31'd1000, 31'd5000, 1'b0, 1'b1, '{16'd0, 31'd1000, 31'd5000, 1'b0}},
            '{31'd1000000, 31'd5000, 1'b0, 1'b0, '0},  // gap wider than time tolerance
            '{31'd1000001, 31'd5000, 1'b1, 1'b0, '0}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_point(directed_rows[i].t, directed_rows[i].d, directed_rows[i].fin,
                       directed_rows[i].typed, directed_rows[i].want);
        drain_kept();

        // Random trajectories, one tolerance setting and idling mode per phase
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin dtol_set = '0;      ttol_set = '0;      end
                1: begin dtol_set = TOL_TOP; ttol_set = TOL_TOP; end
                2: begin dtol_set = '0;      ttol_set = TOL_TOP; end
                3: begin dtol_set = TOL_TOP; ttol_set = '0;      end
                4: begin
                    dtol_set = tdsb_pkg::t_tol'($urandom_range(0, 30000));
                    ttol_set = tdsb_pkg::t_tol'($urandom_range(0, 30000));
                end
                default: begin
                    dtol_set = tdsb_pkg::TOL_RESET;
                    ttol_set = tdsb_pkg::TOL_RESET;
                end
            endcase
            write_tol(tdsb_pkg::CFG_DIST_TOL, dtol_set);
            write_tol(tdsb_pkg::CFG_TIME_TOL, ttol_set);
            settings_used++;
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            // long receiver hold-off while points keep coming
            if (phase == 0) holds_asked++;
            phase_start = points_sent;
            paused = 1'b0;
            while (points_sent - phase_start < ITEMS_PER_PHASE) begin
                if (phase == 3 && !paused &&
                    points_sent - phase_start >= ITEMS_PER_PHASE / 2) begin
                    drain_kept();
                    paused = 1'b1;
                end
                run_trajectory();
            end
            drain_kept();
        end

        if (kept_queue.size() != 0)
            flag_mismatch($sformatf("%0d kept points never arrived", kept_queue.size()));
        $display("Covered %0d points in %0d trajectories over %0d tolerance settings.",
                 points_sent, trajectories, settings_used);
        $display("Checked %0d kept points; %0d points released two at once.",
                 kept_checked, double_kept);
        if (mismatches == 0) begin
            $display("time_distance_slope_bound_compressor_unit verification clean");
        end else begin
            $display("time_distance_slope_bound_compressor_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== time_distance_slope_bound_compressor_unit.f =====
sv/tdsb_pkg.sv
sv/tdsb_in_if.sv
sv/tdsb_out_if.sv
sv/tdsb_div.sv
sv/tdsb_outreg.sv
sv/time_distance_slope_bound_compressor_unit.sv
bench/time_distance_slope_bound_compressor_unit_test.sv
